// ----- sv/pool2d_pkg.sv -----
// Shared types and constants for the 2D max/average pooling unit.
// No dependencies.
package pool2d_pkg;
    localparam int MaxCols    = 256;
    localparam int MaxWindow  = 4;
    localparam int SampleBits = 16;
    localparam int ColBits    = 8;
    localparam int RowBits    = 12;
    localparam int StoreRowBits = 2;
    localparam int AddrBits   = StoreRowBits + ColBits;
    localparam int SumBits    = SampleBits + 4;

    localparam logic [2:0] RegWinRows  = 3'd0;
    localparam logic [2:0] RegWinCols  = 3'd1;
    localparam logic [2:0] RegStepRows = 3'd2;
    localparam logic [2:0] RegStepCols = 3'd3;
    localparam logic [2:0] RegPlaneRows = 3'd4;
    localparam logic [2:0] RegPlaneCols = 3'd5;
    localparam logic [2:0] RegPoolMode = 3'd6;

    // Job handed from the front end to the window engine.
    typedef struct packed {
        logic [RowBits-1:0] r0;       // window top row (plane index)
        logic [ColBits-1:0] c0;       // window left column
        logic [2:0]         wr;       // effective window rows 1..4
        logic [2:0]         wc;       // effective window cols 1..4
        logic               avg;
        logic [RowBits-1:0] out_row;
        logic [ColBits-1:0] out_col;
        logic               last;
    } job_t;

    typedef struct packed {
        logic signed [SampleBits-1:0] value;
        logic [RowBits-1:0]           out_row;
        logic [ColBits-1:0]           out_col;
        logic                         last;
    } result_t;
endpackage

// ----- sv/pool2d_front.sv -----
// Front end: counts raster position, classifies window corners, builds jobs.
// Depends on pool2d_pkg.
module pool2d_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [2:0]                          wr_i,
    input  logic [2:0]                          wc_i,
    input  logic [2:0]                          sr_i,
    input  logic [2:0]                          sc_i,
    input  logic [12:0]                         nr_i,
    input  logic [8:0]                          nc_i,
    input  logic                                avg_i,
    input  logic                                in_fire,
    output logic                                wr_en,
    output logic [pool2d_pkg::AddrBits-1:0]     wr_addr,
    output logic                                row_start,
    output logic                                job_valid,
    output pool2d_pkg::job_t                    job
);
    logic [pool2d_pkg::RowBits-1:0] row_reg, row_next;
    logic [pool2d_pkg::ColBits-1:0] col_reg, col_next;
    // Row/col phase within stride, and pooled output indexes.
    logic [2:0] rph_reg, rph_next, cph_reg, cph_next;
    logic [pool2d_pkg::RowBits-1:0] orow_reg, orow_next;
    logic [pool2d_pkg::ColBits-1:0] ocol_reg, ocol_next;
    logic [12:0] r1, c1, last_r, last_c;
    logic row_end, plane_end, in_plane, r_ok, c_ok;

    // Positions are checked as (pos+1-w) counted by phase counters; phase counts
    // from the first full window, so no division is needed.
    assign r1 = {1'b0, row_reg} + 13'd1;
    assign c1 = {5'b0, col_reg} + 13'd1;
    assign in_plane = (r1 <= nr_i) && (c1 <= {4'b0, nc_i});
    assign r_ok = (r1 >= {10'b0, wr_i}) && (rph_reg == 3'd0);
    assign c_ok = (c1 >= {10'b0, wc_i}) && (cph_reg == 3'd0);
    assign row_end = c1 >= {4'b0, nc_i};
    assign plane_end = row_end && (r1 >= nr_i);
    assign last_r = nr_i - r1;
    assign last_c = {4'b0, nc_i} - c1;

    assign wr_en     = in_fire && in_plane;
    assign wr_addr   = {row_reg[pool2d_pkg::StoreRowBits-1:0], col_reg};
    assign row_start = col_reg == '0;

    // Advance counters and phases.
    always_comb begin
        row_next = row_reg; col_next = col_reg;
        rph_next = rph_reg; cph_next = cph_reg;
        orow_next = orow_reg; ocol_next = ocol_reg;
        if (in_fire) begin
            if (c1 >= {10'b0, wc_i}) begin
                if (c_ok) ocol_next = ocol_reg + 1'b1;
                cph_next = (cph_reg + 3'd1 >= sc_i) ? 3'd0 : cph_reg + 3'd1;
            end
            col_next = col_reg + 1'b1;
            if (row_end) begin
                col_next = '0; cph_next = '0; ocol_next = '0;
                if (r1 >= {10'b0, wr_i}) begin
                    if (r_ok) orow_next = orow_reg + 1'b1;
                    rph_next = (rph_reg + 3'd1 >= sr_i) ? 3'd0 : rph_reg + 3'd1;
                end
                row_next = row_reg + 1'b1;
                if (plane_end) begin
                    row_next = '0; rph_next = '0; orow_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0; col_reg <= '0; rph_reg <= '0; cph_reg <= '0;
            orow_reg <= '0; ocol_reg <= '0;
        end else begin
            row_reg <= row_next; col_reg <= col_next;
            rph_reg <= rph_next; cph_reg <= cph_next;
            orow_reg <= orow_next; ocol_reg <= ocol_next;
        end
    end

    // Last result: no further full window fits below or to the right.
    assign job_valid = wr_en && r_ok && c_ok;
    always_comb begin
        job.r0 = row_reg + 12'd1 - {9'b0, wr_i};
        job.c0 = col_reg + 8'd1 - {5'b0, wc_i};
        job.wr = wr_i;
        job.wc = wc_i;
        job.avg = avg_i;
        job.out_row = orow_reg;
        job.out_col = ocol_reg;
        job.last = (last_r < {10'b0, sr_i}) && (last_c < {10'b0, sc_i});
    end
endmodule

// ----- sv/pool2d_queue.sv -----
// Two-entry job queue between the front end and the window engine.
// Depends on pool2d_pkg.
module pool2d_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pool2d_pkg::job_t push_job,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output pool2d_pkg::job_t head
);
    pool2d_pkg::job_t mem_reg [2];
    logic rd_reg, wr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_job;
    end

    // Advance pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= 1'b0; wr_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- sv/pool2d_engine.sv -----
// Window engine: owns the line store, walks one window a sample per cycle,
// keeps max and sum, divides by the area. Depends on pool2d_pkg.
module pool2d_engine (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  wr_en,
    input  logic [pool2d_pkg::AddrBits-1:0]       wr_addr,
    input  logic signed [pool2d_pkg::SampleBits-1:0] wr_data,
    input  logic                                  job_ready,
    input  pool2d_pkg::job_t                      job,
    output logic                                  job_pop,
    output logic                                  busy,
    output logic                                  res_valid,
    output pool2d_pkg::result_t                   res,
    input  logic                                  res_take
);
    typedef enum logic [2:0] {IDLE, READ, LAST, DIVIDE, HOLD} state_t;
    localparam int SB = pool2d_pkg::SampleBits;
    localparam int SU = pool2d_pkg::SumBits;

    logic signed [SB-1:0] store [pool2d_pkg::MaxWindow*pool2d_pkg::MaxCols];
    logic signed [SB-1:0] rdata_reg;
    state_t state_reg;
    pool2d_pkg::job_t job_reg;
    logic [1:0] i_reg, j_reg;
    logic first_reg, rd_live_reg, rd_first_reg;
    logic signed [SB-1:0] best_reg;
    logic signed [SU-1:0] sum_reg;
    logic [4:0] area;
    logic [SU-1:0] mag_reg, quo_reg, rem_reg;
    logic [4:0] bit_reg;
    logic neg_reg;
    logic [pool2d_pkg::AddrBits-1:0] rd_addr;
    logic [pool2d_pkg::RowBits-1:0] srow;
    logic [pool2d_pkg::ColBits-1:0] scol;
    logic [SU-1:0] rem_sh;
    logic signed [SU-1:0] sum_add;
    logic last_ij;

    assign srow = job_reg.r0 + {10'b0, i_reg};
    assign scol = job_reg.c0 + {6'b0, j_reg};
    assign rd_addr = {srow[1:0], scol};
    assign last_ij = (i_reg == job_reg.wr[1:0] - 2'd1) && (j_reg == job_reg.wc[1:0] - 2'd1);
    assign area = job_reg.wr * job_reg.wc;
    assign rem_sh = {rem_reg[SU-2:0], mag_reg[bit_reg]};
    assign sum_add = sum_reg + SU'(rdata_reg);

    // Write samples, read one window sample per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) store[wr_addr] <= wr_data;
        rdata_reg <= store[rd_addr];
    end

    assign job_pop = (state_reg == IDLE) && job_ready;
    assign busy = state_reg != IDLE;
    assign res_valid = state_reg == HOLD;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            rd_live_reg <= 1'b0;
        end else begin
            // Accumulate the sample read last cycle.
            if (rd_live_reg) begin
                sum_reg <= sum_add;
                if (rd_first_reg || rdata_reg > best_reg) best_reg <= rdata_reg;
            end
            rd_live_reg <= state_reg == READ;
            unique case (state_reg)
                IDLE: begin
                    if (job_ready) begin
                        job_reg <= job; i_reg <= '0; j_reg <= '0;
                        first_reg <= 1'b1; sum_reg <= '0;
                        state_reg <= READ;
                    end
                end
                READ: begin
                    rd_first_reg <= first_reg;
                    first_reg <= 1'b0;
                    if (last_ij) state_reg <= LAST;
                    else if (j_reg == job_reg.wc[1:0] - 2'd1) begin
                        j_reg <= '0; i_reg <= i_reg + 2'd1;
                    end else j_reg <= j_reg + 2'd1;
                end
                LAST: begin
                    // Final accumulate happens this cycle; set up division, or store the result directly.
                    neg_reg <= sum_add[SU-1];
                    mag_reg <= sum_add[SU-1] ? -sum_add : sum_add;
                    rem_reg <= '0; quo_reg <= '0;
                    bit_reg <= 5'(SU - 1);
                    res.out_row <= job_reg.out_row;
                    res.out_col <= job_reg.out_col;
                    res.last <= job_reg.last;
                    if (job_reg.avg && area != 5'd1) state_reg <= DIVIDE;
                    else begin
                        res.value <= job_reg.avg ? sum_add[SB-1:0]
                            : ((first_reg == 1'b0 && rdata_reg > best_reg) || rd_first_reg
                               ? rdata_reg : best_reg);
                        state_reg <= HOLD;
                    end
                end
                DIVIDE: begin
                    // Restoring division, one quotient bit per cycle.
                    if (rem_sh >= {15'b0, area}) begin
                        rem_reg <= rem_sh - {15'b0, area};
                        quo_reg <= {quo_reg[SU-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[SU-2:0], 1'b0};
                    end
                    if (bit_reg == 5'd0) state_reg <= HOLD;
                    bit_reg <= bit_reg - 5'd1;
                end
                HOLD: begin
                    if (res_take) state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
            if (state_reg == DIVIDE && bit_reg == 5'd0) begin
                res.value <= neg_reg
                    ? -((rem_sh >= {15'b0, area}) ? SB'({quo_reg[SU-2:0], 1'b1})
                                                  : SB'({quo_reg[SU-2:0], 1'b0}))
                    : ((rem_sh >= {15'b0, area}) ? SB'({quo_reg[SU-2:0], 1'b1})
                                                 : SB'({quo_reg[SU-2:0], 1'b0}));
            end
        end
    end
endmodule

// ----- sv/pooling_2d_max_average_unit.sv -----
// Top level of the 2D max/average pooling unit: config registers, front end,
// job queue and window engine. Depends on pool2d_pkg and submodules.
//
//   channel | ports                                   | role
//   input   | s_valid s_ready s_sample                | one sample per beat, raster order
//   result  | m_valid m_ready m_pooled_value m_out_*  | one pooled window per beat
//   config  | cfg_we cfg_index cfg_data               | register writes, no wait
//
// A sample is taken while the job queue has room. At the first
// sample of a row the front also waits until no window is queued or in the
// engine, so the line store never overwrites a row that a pending window reads.
// The engine takes a job in IDLE, reads the window in READ, finishes in LAST,
// and divides in DIVIDE for average with an area above one; m_valid is high
// in HOLD and holds until m_ready.
// Reset clears counters, queue and engine; the line store is not cleared.
module pooling_2d_max_average_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_pooled_value,
    output logic [11:0] m_out_row,
    output logic [7:0]  m_out_col,
    output logic        m_plane_done
);
    logic [2:0] wr_reg, wc_reg, sr_reg, sc_reg;
    logic [12:0] nr_reg;
    logic [8:0] nc_reg;
    logic mode_reg;
    logic [2:0] wr_e, wc_e, sr_e, sc_e;
    logic [12:0] nr_e;
    logic [8:0] nc_e;

    // Hold configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= 3'd2; wc_reg <= 3'd2; sr_reg <= 3'd2; sc_reg <= 3'd2;
            nr_reg <= 13'd28; nc_reg <= 9'd28; mode_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pool2d_pkg::RegWinRows:   wr_reg <= cfg_data[2:0];
                pool2d_pkg::RegWinCols:   wc_reg <= cfg_data[2:0];
                pool2d_pkg::RegStepRows:  sr_reg <= cfg_data[2:0];
                pool2d_pkg::RegStepCols:  sc_reg <= cfg_data[2:0];
                pool2d_pkg::RegPlaneRows: nr_reg <= cfg_data;
                pool2d_pkg::RegPlaneCols: nc_reg <= cfg_data[8:0];
                pool2d_pkg::RegPoolMode:  mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp to legal ranges.
    assign wr_e = (wr_reg == 3'd0) ? 3'd1 : (wr_reg > 3'd4) ? 3'd4 : wr_reg;
    assign wc_e = (wc_reg == 3'd0) ? 3'd1 : (wc_reg > 3'd4) ? 3'd4 : wc_reg;
    assign sr_e = (sr_reg == 3'd0) ? 3'd1 : sr_reg;
    assign sc_e = (sc_reg == 3'd0) ? 3'd1 : sc_reg;
    assign nr_e = (nr_reg == 13'd0) ? 13'd1 : (nr_reg > 13'd4096) ? 13'd4096 : nr_reg;
    assign nc_e = (nc_reg == 9'd0) ? 9'd1 : (nc_reg > 9'd256) ? 9'd256 : nc_reg;

    logic in_fire, st_we, jv, q_full, q_empty, pop, ev, row_start, eng_busy;
    logic [pool2d_pkg::AddrBits-1:0] st_addr;
    pool2d_pkg::job_t fjob, qhead;
    pool2d_pkg::result_t eres;

    // Stall while the queue is full, and hold a new row until every window of the previous row has left.
    assign s_ready = !q_full && !(row_start && (eng_busy || !q_empty));
    assign in_fire = s_valid && s_ready;

    pool2d_front u_front (
        .aclk, .aresetn, .wr_i(wr_e), .wc_i(wc_e), .sr_i(sr_e), .sc_i(sc_e),
        .nr_i(nr_e), .nc_i(nc_e), .avg_i(mode_reg), .in_fire,
        .wr_en(st_we), .wr_addr(st_addr), .row_start, .job_valid(jv), .job(fjob)
    );

    pool2d_queue u_queue (
        .aclk, .aresetn, .push(jv), .push_job(fjob), .full(q_full),
        .empty(q_empty), .pop, .head(qhead)
    );

    pool2d_engine u_engine (
        .aclk, .aresetn, .wr_en(st_we), .wr_addr(st_addr), .wr_data(s_sample),
        .job_ready(!q_empty), .job(qhead), .job_pop(pop), .busy(eng_busy),
        .res_valid(ev), .res(eres), .res_take(m_ready)
    );

    assign m_valid = ev;
    assign m_pooled_value = eres.value;
    assign m_out_row = eres.out_row;
    assign m_out_col = eres.out_col;
    assign m_plane_done = eres.last;
endmodule

// ----- sv/pool2d_checker.sv -----
// Port-level checker for the pooling unit, bound to the top level.
// Depends only on the top-level ports.
module pool2d_checker (
    input logic aclk, aresetn, s_ready, m_valid, m_ready,
    input logic [15:0] m_pooled_value
);
    a_mhold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pooled_value)) else $error("result dropped");
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("result after reset");
    a_ready_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready) else $error("not ready after reset");
endmodule

bind pooling_2d_max_average_unit pool2d_checker u_chk (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready, .m_pooled_value
);

// ----- bench/pool2d_scoreboard.sv -----
// Scoreboard for the 2D max/average pooling unit: watches the config port and both
// beat channels, predicts each pooled window and checks it. Depends on pool2d_pkg.
module pool2d_scoreboard (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_sample,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_pooled_value,
    input  logic [11:0]        m_out_row,
    input  logic [7:0]         m_out_col,
    input  logic               m_plane_done,
    output int                 err_count,
    output int                 pending,
    output int                 windows_seen
);
    logic signed [pool2d_pkg::SampleBits-1:0]
        rows_kept [0:pool2d_pkg::MaxWindow-1][0:pool2d_pkg::MaxCols-1];
    pool2d_pkg::result_t window_q[$];

    logic [2:0]  win_rows, win_cols, step_rows, step_cols;
    logic [12:0] plane_rows;
    logic [8:0]  plane_cols;
    logic        avg_mode;
    int          row_pos, col_pos;

    function automatic int fit(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Store the sample and, at a window's bottom-right corner, queue its result.
    task automatic take_sample(input logic signed [15:0] v);
        int wr, wc, sr, sc, nr, nc, r0, c0, last_r, last_c, sum;
        logic signed [15:0] best, x;
        pool2d_pkg::result_t res;
        wr = fit(win_rows, pool2d_pkg::MaxWindow);
        wc = fit(win_cols, pool2d_pkg::MaxWindow);
        sr = fit(step_rows, 8);
        sc = fit(step_cols, 8);
        nr = fit(plane_rows, 4096);
        nc = fit(plane_cols, pool2d_pkg::MaxCols);
        if (row_pos < nr && col_pos < nc) begin
            rows_kept[row_pos % pool2d_pkg::MaxWindow][col_pos] = v;
            if (row_pos + 1 >= wr && col_pos + 1 >= wc &&
                (row_pos + 1 - wr) % sr == 0 && (col_pos + 1 - wc) % sc == 0 &&
                nr >= wr && nc >= wc) begin
                r0 = row_pos + 1 - wr;
                c0 = col_pos + 1 - wc;
                last_r = ((nr - wr) / sr) * sr + wr - 1;
                last_c = ((nc - wc) / sc) * sc + wc - 1;
                sum = 0;
                best = rows_kept[r0 % pool2d_pkg::MaxWindow][c0];
                for (int i = 0; i < wr; i++)
                    for (int j = 0; j < wc; j++) begin
                        x = rows_kept[(r0 + i) % pool2d_pkg::MaxWindow][c0 + j];
                        sum += x;
                        if (x > best) best = x;
                    end
                res.value   = avg_mode ? 16'(sum / (wr * wc)) : best;
                res.out_row = 12'(r0 / sr);
                res.out_col = 8'(c0 / sc);
                res.last    = (row_pos == last_r && col_pos == last_c);
                window_q = {window_q, res};
            end
        end
        // Advance the raster position, wrapping at row and plane ends.
        if (col_pos + 1 >= nc) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= nr) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic check_window();
        pool2d_pkg::result_t exp_r;
        if (window_q.size() == 0) begin
            $display("%0t: unexpected result beat value %0d row %0d col %0d", $time,
                     m_pooled_value, m_out_row, m_out_col);
            err_count++;
            return;
        end
        exp_r = window_q.pop_front();
        windows_seen++;
        if (m_pooled_value !== exp_r.value) begin
            $display("%0t: pooled_value expected %0d actual %0d", $time,
                     $signed(exp_r.value), m_pooled_value);
            err_count++;
        end
        if (m_out_row !== exp_r.out_row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, exp_r.out_row, m_out_row);
            err_count++;
        end
        if (m_out_col !== exp_r.out_col) begin
            $display("%0t: out_col expected %0d actual %0d", $time, exp_r.out_col, m_out_col);
            err_count++;
        end
        if (m_plane_done !== exp_r.last) begin
            $display("%0t: plane_done expected %0d actual %0d", $time,
                     exp_r.last, m_plane_done);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            win_rows     <= 3'd2;
            win_cols     <= 3'd2;
            step_rows    <= 3'd2;
            step_cols    <= 3'd2;
            plane_rows   <= 13'd28;
            plane_cols   <= 9'd28;
            avg_mode     <= 1'b0;
            row_pos      = 0;
            col_pos      = 0;
            err_count    = 0;
            windows_seen = 0;
            window_q.delete();
        end else begin
            if (m_valid && m_ready) check_window();
            if (s_valid && s_ready) take_sample(s_sample);
            // Mirror register writes; they apply from the next cycle on.
            if (cfg_we) begin
                case (cfg_index)
                    pool2d_pkg::RegWinRows:   win_rows   <= cfg_data[2:0];
                    pool2d_pkg::RegWinCols:   win_cols   <= cfg_data[2:0];
                    pool2d_pkg::RegStepRows:  step_rows  <= cfg_data[2:0];
                    pool2d_pkg::RegStepCols:  step_cols  <= cfg_data[2:0];
                    pool2d_pkg::RegPlaneRows: plane_rows <= cfg_data[12:0];
                    pool2d_pkg::RegPlaneCols: plane_cols <= cfg_data[8:0];
                    pool2d_pkg::RegPoolMode:  avg_mode   <= cfg_data[0];
                    default: ;
                endcase
            end
        end
        pending = window_q.size();
    end
endmodule

// ----- bench/pooling_2d_max_average_unit_tb.sv -----
// Top of the pooling unit bench: clock, reset, sample and config stimulus, verdict.
// Depends on pool2d_pkg, pooling_2d_max_average_unit and pool2d_scoreboard.
module pooling_2d_max_average_unit_tb;
    localparam int ItemTarget = 1650;
    localparam int StallLimit = 5000;
    localparam int DrainWait  = 100;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [12:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_sample = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_pooled_value;
    logic [11:0]        m_out_row;
    logic [7:0]         m_out_col;
    logic               m_plane_done;

    int err_count, pending, windows_seen;
    int items_sent = 0;
    int planes_sent = 0;
    int send_idle = 38;
    int recv_idle = 65;
    int plane_len;
    int stall_cycles = 0;

    pooling_2d_max_average_unit u_dut (.*);

    pool2d_scoreboard u_scoreboard (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: stall at the current rate.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Watchdog: end the run if no beat moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("%0t: no beat for %0d cycles, %0d windows outstanding", $time,
                     StallLimit, pending);
            $display("pooling_2d_max_average_unit regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int fit(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Hold off until every window has come back and the engine is surely quiet.
    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 13'(val);
        @(posedge aclk);
    endtask

    task automatic program_plane(input int wr, input int wc, input int sr, input int sc,
                                 input int pr, input int pc, input int md);
        drain();
        write_reg(pool2d_pkg::RegWinRows, wr);
        write_reg(pool2d_pkg::RegWinCols, wc);
        write_reg(pool2d_pkg::RegStepRows, sr);
        write_reg(pool2d_pkg::RegStepCols, sc);
        write_reg(pool2d_pkg::RegPlaneRows, pr);
        write_reg(pool2d_pkg::RegPlaneCols, pc);
        write_reg(pool2d_pkg::RegPoolMode, md);
        cfg_we <= 1'b0;
        plane_len = fit(pr, 4096) * fit(pc, pool2d_pkg::MaxCols);
        planes_sent++;
    endtask

    task automatic send_sample(input logic [15:0] v);
        // Switch idle profile by progress: receiver-heavy, sender-heavy, then none.
        if (items_sent < ItemTarget / 3) begin
            send_idle = 38; recv_idle = 65;
        end else if (items_sent < 2 * ItemTarget / 3) begin
            send_idle = 65; recv_idle = 38;
        end else begin
            send_idle = 0; recv_idle = 0;
        end
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(($urandom_range(0, 15)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_plane();
        for (int i = 0; i < plane_len; i++) send_sample(rand_sample());
        s_valid <= 1'b0;
    endtask

    function automatic int pick_window();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(5, 7);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    function automatic int pick_step();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(5, 7);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    initial begin
        logic [15:0] corner_vals [16];
        logic [15:0] trunc_vals [6];
        corner_vals = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff,
                        16'h8000, 16'h8000, 16'h8000, 16'h8000,
                        16'h7fff, 16'h7fff, 16'h0001, 16'h7ffe,
                        16'h0100, 16'hff00, 16'h0080, 16'hff80};
        trunc_vals  = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme samples, max pooling on a 4x4 plane.
        program_plane(2, 2, 2, 2, 4, 4, 0);
        foreach (corner_vals[i]) send_sample(corner_vals[i]);
        s_valid <= 1'b0;
        // Directed: negative average truncates toward zero.
        program_plane(2, 3, 1, 1, 2, 3, 1);
        foreach (trunc_vals[i]) send_sample(trunc_vals[i]);
        s_valid <= 1'b0;
        // Directed: window larger than the plane gives nothing.
        program_plane(4, 4, 1, 1, 2, 2, 0);
        send_random_plane();

        // Directed: oversized and zero window fields, zero column stride, average mode.
        program_plane(7, 0, 4, 0, 6, 9, 1);
        send_random_plane();
        // Directed: zero plane rows and oversized plane columns.
        program_plane(0, 4, 0, 3, 0, 511, 0);
        send_random_plane();

        // Random planes with random content until the item budget is spent.
        while (items_sent < ItemTarget) begin
            program_plane(pick_window(), pick_window(), pick_step(), pick_step(),
                          ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 16),
                          ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24),
                          $urandom_range(0, 1));
            send_random_plane();
        end

        drain();
        $display("Covered %0d samples over %0d planes, %0d pooled windows checked,", items_sent,
                 planes_sent, windows_seen);
        $display("max and average modes, clamped window, stride and plane sizes.");
        if (err_count == 0) begin
            $display("pooling_2d_max_average_unit regression: pass");
        end else begin
            $display("pooling_2d_max_average_unit regression: fail");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
sv/pool2d_pkg.sv
sv/pool2d_front.sv
sv/pool2d_queue.sv
sv/pool2d_engine.sv
sv/pooling_2d_max_average_unit.sv
sv/pool2d_checker.sv
bench/pool2d_scoreboard.sv
bench/pooling_2d_max_average_unit_tb.sv
